FILE: hw/rtl/demand_paging_fifo_mmu_macros.svh
// assertion macros for the demand paging mmu
`ifndef DEMAND_PAGING_FIFO_MMU_MACROS_SVH
`define DEMAND_PAGING_FIFO_MMU_MACROS_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define DPFM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define DPFM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/dpfm_pkg.sv
// types and constants of the demand paging mmu
package dpfm_pkg;

  localparam int unsigned PAGE_BYTES    = 8;
  localparam int unsigned NUM_PAGES     = 16;
  localparam int unsigned NUM_FRAMES    = 8;
  localparam int unsigned MAX_PROCESSES = 2;
  localparam int unsigned SWAP_SLOTS    = 32;

  localparam int unsigned OFF_W   = $clog2(PAGE_BYTES);
  localparam int unsigned PAGE_W  = $clog2(NUM_PAGES);
  localparam int unsigned FRAME_W = $clog2(NUM_FRAMES);
  localparam int unsigned PROC_W  = $clog2(MAX_PROCESSES);
  localparam int unsigned SLOT_W  = $clog2(SWAP_SLOTS);
  localparam int unsigned ADDR_W  = 7;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned STAT_W  = 3;
  localparam int unsigned LIM_W   = 5;
  localparam int unsigned PCNT_W  = 2;

  localparam int unsigned PE_IDX_W = PROC_W + PAGE_W;
  localparam int unsigned PE_DEPTH = MAX_PROCESSES * NUM_PAGES;

  // free slot search: groups of eight slots
  localparam int unsigned GRP_SIZE = 8;
  localparam int unsigned GRP_W    = $clog2(GRP_SIZE);
  localparam int unsigned NUM_GRP  = SWAP_SLOTS / GRP_SIZE;
  localparam int unsigned GIDX_W   = SLOT_W - GRP_W;

  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 40;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 5;

  localparam logic OP_STORE = 1'b1;

  localparam logic [STAT_W-1:0] STAT_HIT      = 3'd0;
  localparam logic [STAT_W-1:0] STAT_EXE      = 3'd1;
  localparam logic [STAT_W-1:0] STAT_ZERO     = 3'd2;
  localparam logic [STAT_W-1:0] STAT_SWAP     = 3'd3;
  localparam logic [STAT_W-1:0] STAT_TEXT_WR  = 3'd4;
  localparam logic [STAT_W-1:0] STAT_UNSTORED = 3'd5;
  localparam logic [STAT_W-1:0] STAT_BAD_PROC = 3'd6;

  localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TEXT_LIMIT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_END      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BSS_END       = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOKUP,
    S_VICTIM
  } state_e;

  // page table word; valid and in-swap flags live in flops
  typedef struct packed {
    logic [SLOT_W-1:0]  slot;
    logic [FRAME_W-1:0] frame;
  } pe_word_t;

  // frame owner word; the occupied flag lives in flops
  typedef struct packed {
    logic [PROC_W-1:0] owner;
    logic [PAGE_W-1:0] page;
    logic              dirty;
  } fo_word_t;

endpackage

FILE: hw/rtl/demand_paging_fifo_mmu.sv
// demand paging mmu with fifo frame replacement and swap slot allocation
// the result is registered from the lookup state, which waits while the output stalls
// a new item is taken only in idle, after the lookup and any victim write of the last item
// that victim write, done when a dirty victim gets a swap slot, is a second access to the page table memory
// reset clears all valid, in-swap, occupied and slot-used flags at once; no clearing pass
// configuration resets to process_count 1 and all page limits 0
module demand_paging_fifo_mmu (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input items
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // operation[0], process[1], address[8:2], store_value[16:9], zeros above
  input  logic [dpfm_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,
  // result items
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // status[2:0], frame[5:3], physical_address[11:6], write_data[19:12],
  // victim_valid[20], victim_process[21], victim_page[25:22], victim_to_swap[26],
  // swap_out_slot[31:27], swap_in_valid[32], swap_in_slot[37:33], zeros above
  output logic [dpfm_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o,
  // configuration writes
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [dpfm_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [dpfm_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [dpfm_pkg::PCNT_W-1:0] pcount_q;
  logic [dpfm_pkg::LIM_W-1:0]  text_q, data_end_q, bss_end_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcount_q   <= dpfm_pkg::PCNT_W'(1);
      text_q     <= '0;
      data_end_q <= '0;
      bss_end_q  <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        dpfm_pkg::CFG_PROCESS_COUNT: pcount_q   <= cfg_data_i[dpfm_pkg::PCNT_W-1:0];
        dpfm_pkg::CFG_TEXT_LIMIT:    text_q     <= cfg_data_i;
        dpfm_pkg::CFG_DATA_END:      data_end_q <= cfg_data_i;
        dpfm_pkg::CFG_BSS_END:       bss_end_q  <= cfg_data_i;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // control
  // ---------------------------------------------------------------------------
  dpfm_pkg::state_e state_q, state_d;
  logic in_accept;
  logic lookup_done;
  logic victim_wr;
  logic vic_swap;

  assign in_accept = s_axis_tvalid_i && s_axis_tready_o;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dpfm_pkg::S_IDLE: begin
        if (in_accept) state_d = dpfm_pkg::S_LOOKUP;
      end
      dpfm_pkg::S_LOOKUP: begin
        if (lookup_done) state_d = vic_swap ? dpfm_pkg::S_VICTIM : dpfm_pkg::S_IDLE;
      end
      dpfm_pkg::S_VICTIM: state_d = dpfm_pkg::S_IDLE;
      default:            state_d = dpfm_pkg::S_IDLE;
    endcase
  end

  // state outputs: lookup finishes once the output register can take the result
  always_comb begin
    s_axis_tready_o = 1'b0;
    lookup_done     = 1'b0;
    victim_wr       = 1'b0;
    unique case (state_q)
      dpfm_pkg::S_IDLE:   s_axis_tready_o = 1'b1;
      dpfm_pkg::S_LOOKUP: lookup_done = !m_axis_tvalid_o || m_axis_tready_i;
      dpfm_pkg::S_VICTIM: victim_wr = 1'b1;
      default:            ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= dpfm_pkg::S_IDLE;
    else         state_q <= state_d;
  end

  // ---------------------------------------------------------------------------
  // input item register
  // ---------------------------------------------------------------------------
  logic                          op_q;
  logic [dpfm_pkg::PROC_W-1:0]   proc_q;
  logic [dpfm_pkg::PAGE_W-1:0]   page_q;
  logic [dpfm_pkg::OFF_W-1:0]    off_q;
  logic [dpfm_pkg::BYTE_W-1:0]   val_q;
  logic [dpfm_pkg::PROC_W-1:0]   in_proc;
  logic [dpfm_pkg::ADDR_W-1:0]   in_addr;
  logic [dpfm_pkg::PAGE_W-1:0]   in_page;

  assign in_proc = s_axis_tdata_i[1];
  assign in_addr = s_axis_tdata_i[8:2];
  // page number is the address bits above the offset
  assign in_page = in_addr[dpfm_pkg::OFF_W +: dpfm_pkg::PAGE_W];

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q   <= s_axis_tdata_i[0];
      proc_q <= in_proc;
      page_q <= in_page;
      off_q  <= in_addr[dpfm_pkg::OFF_W-1:0];
      val_q  <= s_axis_tdata_i[16:9];
    end
  end

  // ---------------------------------------------------------------------------
  // memories: page table words and frame owners, registered read
  // ---------------------------------------------------------------------------
  dpfm_pkg::pe_word_t pe_mem [dpfm_pkg::PE_DEPTH];
  dpfm_pkg::pe_word_t pe_rdata_q;
  dpfm_pkg::pe_word_t pe_wdata;
  logic [dpfm_pkg::PE_IDX_W-1:0] pe_waddr;
  logic                          pe_we;

  dpfm_pkg::fo_word_t fo_mem [dpfm_pkg::NUM_FRAMES];
  dpfm_pkg::fo_word_t fo_rdata_q;
  dpfm_pkg::fo_word_t fo_wdata;
  logic [dpfm_pkg::FRAME_W-1:0] fo_waddr;
  logic                         fo_we;

  logic [dpfm_pkg::FRAME_W-1:0] fifo_ptr_q;

  // both reads are issued on the accepting edge; no write is pending then
  always_ff @(posedge clk_i) begin
    if (pe_we) pe_mem[pe_waddr] <= pe_wdata;
    if (in_accept) pe_rdata_q <= pe_mem[{in_proc, in_page}];
  end

  always_ff @(posedge clk_i) begin
    if (fo_we) fo_mem[fo_waddr] <= fo_wdata;
    if (in_accept) fo_rdata_q <= fo_mem[fifo_ptr_q];
  end

  // per-entry flags in flops so reset takes effect at once
  logic [dpfm_pkg::PE_DEPTH-1:0]   pe_valid_q, pe_valid_d;
  logic [dpfm_pkg::PE_DEPTH-1:0]   pe_swp_q, pe_swp_d;
  logic [dpfm_pkg::NUM_FRAMES-1:0] fo_used_q, fo_used_d;
  logic [dpfm_pkg::SWAP_SLOTS-1:0] swap_used_q, swap_used_d;
  logic [dpfm_pkg::FRAME_W-1:0]    fifo_ptr_d;

  // ---------------------------------------------------------------------------
  // lowest free swap slot, registered; refreshed well before the next lookup
  // ---------------------------------------------------------------------------
  logic                        free_found_q, free_found_d;
  logic [dpfm_pkg::SLOT_W-1:0] free_slot_q, free_slot_d;
  logic [dpfm_pkg::NUM_GRP-1:0] grp_found;
  logic [dpfm_pkg::GRP_W-1:0]   grp_slot [dpfm_pkg::NUM_GRP];

  always_comb begin
    for (int g = 0; g < dpfm_pkg::NUM_GRP; g++) begin
      grp_found[g] = 1'b0;
      grp_slot[g]  = '0;
      for (int k = dpfm_pkg::GRP_SIZE - 1; k >= 0; k--) begin
        if (!swap_used_q[g * dpfm_pkg::GRP_SIZE + k]) begin
          grp_found[g] = 1'b1;
          grp_slot[g]  = dpfm_pkg::GRP_W'(k);
        end
      end
    end
    free_found_d = 1'b0;
    free_slot_d  = '0;
    for (int g = dpfm_pkg::NUM_GRP - 1; g >= 0; g--) begin
      if (grp_found[g]) begin
        free_found_d = 1'b1;
        free_slot_d  = {dpfm_pkg::GIDX_W'(g), grp_slot[g]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_found_q <= 1'b1;
      free_slot_q  <= '0;
    end else begin
      free_found_q <= free_found_d;
      free_slot_q  <= free_slot_d;
    end
  end

  // ---------------------------------------------------------------------------
  // lookup: classify the access, pick the victim, build the result
  // ---------------------------------------------------------------------------
  logic [dpfm_pkg::PE_IDX_W-1:0] cur_idx, vic_idx;
  logic                          cur_valid, cur_swp, is_store;
  logic                          err, fill, evict, swap_in, hit_store;
  logic [dpfm_pkg::STAT_W-1:0]   status;
  logic [dpfm_pkg::FRAME_W-1:0]  frame;
  logic [dpfm_pkg::LIM_W-1:0]    page_ext;

  assign cur_idx   = {proc_q, page_q};
  assign cur_valid = pe_valid_q[cur_idx];
  assign cur_swp   = pe_swp_q[cur_idx];
  assign is_store  = (op_q == dpfm_pkg::OP_STORE);
  assign page_ext  = dpfm_pkg::LIM_W'(page_q);

  always_comb begin
    err    = 1'b1;
    status = dpfm_pkg::STAT_HIT;
    priority if ({1'b0, proc_q} >= pcount_q) begin
      status = dpfm_pkg::STAT_BAD_PROC;
    end else if (is_store && page_ext < text_q) begin
      status = dpfm_pkg::STAT_TEXT_WR;
    end else if (cur_valid) begin
      err    = 1'b0;
      status = dpfm_pkg::STAT_HIT;
    end else if (cur_swp) begin
      err    = 1'b0;
      status = dpfm_pkg::STAT_SWAP;
    end else if (page_ext < text_q) begin
      err    = 1'b0;
      status = dpfm_pkg::STAT_EXE;
    end else if (!is_store && page_ext >= bss_end_q) begin
      status = dpfm_pkg::STAT_UNSTORED;
    end else if (page_ext >= data_end_q) begin
      err    = 1'b0;
      status = dpfm_pkg::STAT_ZERO;
    end else begin
      err    = 1'b0;
      status = dpfm_pkg::STAT_EXE;
    end
  end

  assign fill      = !err && !cur_valid;
  assign hit_store = !err && cur_valid && is_store;
  assign swap_in   = fill && cur_swp;
  assign evict     = fill && fo_used_q[fifo_ptr_q];
  assign vic_idx   = {fo_rdata_q.owner, fo_rdata_q.page};
  // dirty victim goes to swap only if a slot is free, else it is dropped clean
  assign vic_swap  = evict && fo_rdata_q.dirty && free_found_q;
  assign frame     = cur_valid ? pe_rdata_q.frame : fifo_ptr_q;

  // victim page table write, done in the cycle after the lookup
  logic [dpfm_pkg::PE_IDX_W-1:0] vic_idx_q;
  logic [dpfm_pkg::SLOT_W-1:0]   vic_slot_q;

  always_ff @(posedge clk_i) begin
    if (lookup_done) begin
      vic_idx_q  <= vic_idx;
      vic_slot_q <= free_slot_q;
    end
  end

  always_comb begin
    pe_we    = 1'b0;
    pe_waddr = cur_idx;
    pe_wdata = '{slot: pe_rdata_q.slot, frame: fifo_ptr_q};
    if (victim_wr) begin
      pe_we    = 1'b1;
      pe_waddr = vic_idx_q;
      pe_wdata = '{slot: vic_slot_q, frame: '0};
    end else if (lookup_done && fill) begin
      pe_we = 1'b1;
    end
  end

  // frame owner carries the dirty flag of the resident page; an invalid page is
  // dirty exactly when it sits in swap, so a refill takes in-swap or store
  always_comb begin
    fo_we    = 1'b0;
    fo_waddr = fifo_ptr_q;
    fo_wdata = '{owner: proc_q, page: page_q, dirty: cur_swp || is_store};
    if (lookup_done && fill) begin
      fo_we = 1'b1;
    end else if (lookup_done && hit_store) begin
      fo_we    = 1'b1;
      fo_waddr = pe_rdata_q.frame;
      fo_wdata = '{owner: proc_q, page: page_q, dirty: 1'b1};
    end
  end

  // flag updates; the victim's slot is taken before the incoming slot is freed
  always_comb begin
    pe_valid_d  = pe_valid_q;
    pe_swp_d    = pe_swp_q;
    fo_used_d   = fo_used_q;
    swap_used_d = swap_used_q;
    fifo_ptr_d  = fifo_ptr_q;
    if (lookup_done && fill) begin
      if (evict) begin
        pe_valid_d[vic_idx] = 1'b0;
        pe_swp_d[vic_idx]   = vic_swap;
      end
      if (vic_swap) swap_used_d[free_slot_q] = 1'b1;
      if (swap_in)  swap_used_d[pe_rdata_q.slot] = 1'b0;
      pe_valid_d[cur_idx]   = 1'b1;
      pe_swp_d[cur_idx]     = 1'b0;
      fo_used_d[fifo_ptr_q] = 1'b1;
      fifo_ptr_d            = fifo_ptr_q + dpfm_pkg::FRAME_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pe_valid_q  <= '0;
      pe_swp_q    <= '0;
      fo_used_q   <= '0;
      swap_used_q <= '0;
      fifo_ptr_q  <= '0;
    end else begin
      pe_valid_q  <= pe_valid_d;
      pe_swp_q    <= pe_swp_d;
      fo_used_q   <= fo_used_d;
      swap_used_q <= swap_used_d;
      fifo_ptr_q  <= fifo_ptr_d;
    end
  end

  // ---------------------------------------------------------------------------
  // output register; error results carry zeros besides the status
  // ---------------------------------------------------------------------------
  logic [dpfm_pkg::OUT_TDATA_W-1:0] out_tdata_q, out_tdata_d;
  logic                             out_valid_q, out_valid_d;

  always_comb begin
    out_tdata_d = '0;
    out_tdata_d[2:0] = status;
    if (!err) begin
      out_tdata_d[5:3]   = frame;
      out_tdata_d[11:6]  = {frame, off_q};
      out_tdata_d[19:12] = is_store ? val_q : '0;
      out_tdata_d[20]    = evict;
      out_tdata_d[21]    = evict ? fo_rdata_q.owner : 1'b0;
      out_tdata_d[25:22] = evict ? fo_rdata_q.page : '0;
      out_tdata_d[26]    = vic_swap;
      out_tdata_d[31:27] = vic_swap ? free_slot_q : '0;
      out_tdata_d[32]    = swap_in;
      out_tdata_d[37:33] = swap_in ? pe_rdata_q.slot : '0;
    end
  end

  assign out_valid_d = lookup_done || (out_valid_q && !m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else         out_valid_q <= out_valid_d;
  end

  always_ff @(posedge clk_i) begin
    if (lookup_done) out_tdata_q <= out_tdata_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_tdata_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
`include "demand_paging_fifo_mmu_macros.svh"

  `DPFM_ASSERT_NXT(a_fifo_step, lookup_done && fill, fifo_ptr_q == $past(fifo_ptr_q) + 3'd1, "fifo pointer did not advance on a fill")
  `DPFM_ASSERT_IMP(a_slot_free, lookup_done && vic_swap, !swap_used_q[free_slot_q], "allocated swap slot already in use")
  `DPFM_ASSERT_IMP(a_victim_other, lookup_done && evict, vic_idx != cur_idx, "victim page equals the page being filled")

endmodule
